// ===== design/m3i_pkg.sv =====
package m3i_pkg;

  // Element and intermediate widths (Q format set by the top-level FRAC_BITS)
  localparam int EW = 16;          // element width
  localparam int NE = 9;           // elements per matrix
  localparam int PW = 2 * EW;      // element product
  localparam int CW = PW + 1;      // cofactor
  localparam int TW = EW + CW;     // element times cofactor
  localparam int DW = TW + 2;      // determinant, sum of three terms

  // Input word: column-major, index = column*3 + row
  typedef struct packed {
    logic signed [EW-1:0] in_0;
    logic signed [EW-1:0] in_1;
    logic signed [EW-1:0] in_2;
    logic signed [EW-1:0] in_3;
    logic signed [EW-1:0] in_4;
    logic signed [EW-1:0] in_5;
    logic signed [EW-1:0] in_6;
    logic signed [EW-1:0] in_7;
    logic signed [EW-1:0] in_8;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [EW-1:0] out_0;
    logic signed [EW-1:0] out_1;
    logic signed [EW-1:0] out_2;
    logic signed [EW-1:0] out_3;
    logic signed [EW-1:0] out_4;
    logic signed [EW-1:0] out_5;
    logic signed [EW-1:0] out_6;
    logic signed [EW-1:0] out_7;
    logic signed [EW-1:0] out_8;
    logic                 singular;
  } out_word_t;

  // Matrix entering the cofactor stages
  typedef struct packed {
    logic                     vld;
    logic [NE-1:0][EW-1:0]    m;
  } mat_in_t;

  // Cofactors plus first-row elements (m0, m3, m6)
  typedef struct packed {
    logic                     vld;
    logic [2:0][EW-1:0]       r;
    logic [NE-1:0][CW-1:0]    c;
  } cof_b_t;

  // Sign/magnitude form handed to the divider
  typedef struct packed {
    logic                     vld;
    logic                     zero;
    logic [NE-1:0]            neg;
    logic [NE-1:0][CW-1:0]    cmag;
    logic [DW-1:0]            dmag;
  } div_in_t;

  // Saturated quotients
  typedef struct packed {
    logic                     vld;
    logic                     singular;
    logic [NE-1:0][EW-1:0]    q;
  } res_t;

endpackage

// ===== design/m3i_cof.sv =====
module m3i_cof (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  m3i_pkg::mat_in_t  mi,
  output m3i_pkg::cof_b_t   co
);
  import m3i_pkg::*;

  typedef logic [3:0] eidx_t;

  // cof[k] = m[a]*m[b] - m[c]*m[d], adjugate already transposed
  localparam eidx_t CO_IDX [NE][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic                     vld;
    logic [2:0][EW-1:0]       r;
    logic [2*NE-1:0][PW-1:0]  p;
  } cof_a_t;

  cof_a_t a_r, a_nxt;
  cof_b_t b_r, b_nxt;

  // Stage A: eighteen element products
  always_comb begin
    a_nxt.vld = mi.vld;
    a_nxt.r   = {mi.m[6], mi.m[3], mi.m[0]};
    for (int k = 0; k < NE; k++) begin
      a_nxt.p[2*k]   = $signed(mi.m[CO_IDX[k][0]]) * $signed(mi.m[CO_IDX[k][1]]);
      a_nxt.p[2*k+1] = $signed(mi.m[CO_IDX[k][2]]) * $signed(mi.m[CO_IDX[k][3]]);
    end
  end

  // Stage B: cofactor differences
  always_comb begin
    b_nxt.vld = a_r.vld;
    b_nxt.r   = a_r.r;
    for (int k = 0; k < NE; k++) begin
      b_nxt.c[k] = $signed({a_r.p[2*k][PW-1], a_r.p[2*k]})
                 - $signed({a_r.p[2*k+1][PW-1], a_r.p[2*k+1]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign co = b_r;

endmodule

// ===== design/m3i_det.sv =====
module m3i_det (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  m3i_pkg::cof_b_t   ci,
  output m3i_pkg::div_in_t  dv
);
  import m3i_pkg::*;

  typedef struct packed {
    logic                     vld;
    logic [NE-1:0][CW-1:0]    c;
    logic [2:0][TW-1:0]       t;
  } det_c_t;

  typedef struct packed {
    logic                     vld;
    logic [NE-1:0][CW-1:0]    c;
    logic [DW-1:0]            det;
  } det_d_t;

  det_c_t  c_r, c_nxt;
  det_d_t  d_r, d_nxt;
  div_in_t e_r, e_nxt;
  logic    dneg;

  // Stage C: first-row terms
  always_comb begin
    c_nxt.vld = ci.vld;
    c_nxt.c   = ci.c;
    for (int j = 0; j < 3; j++) begin
      c_nxt.t[j] = $signed(ci.r[j]) * $signed(ci.c[j]);
    end
  end

  // Stage D: determinant
  always_comb begin
    d_nxt.vld = c_r.vld;
    d_nxt.c   = c_r.c;
    d_nxt.det = $signed({{2{c_r.t[0][TW-1]}}, c_r.t[0]})
              + $signed({{2{c_r.t[1][TW-1]}}, c_r.t[1]})
              + $signed({{2{c_r.t[2][TW-1]}}, c_r.t[2]});
  end

  // Stage E: sign/magnitude split
  assign dneg = d_r.det[DW-1];

  always_comb begin
    e_nxt.vld  = d_r.vld;
    e_nxt.zero = (d_r.det == '0);
    e_nxt.dmag = dneg ? (~d_r.det + 1'b1) : d_r.det;
    for (int k = 0; k < NE; k++) begin
      e_nxt.neg[k]  = d_r.c[k][CW-1] ^ dneg;
      e_nxt.cmag[k] = d_r.c[k][CW-1] ? (~d_r.c[k] + 1'b1) : d_r.c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
      d_r.vld <= 1'b0;
      e_r.vld <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
      d_r <= d_nxt;
      e_r <= e_nxt;
    end
  end

  assign dv = e_r;

endmodule

// ===== design/m3i_div.sv =====
module m3i_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  m3i_pkg::div_in_t  di,
  output m3i_pkg::res_t     ro
);
  import m3i_pkg::*;

  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int XW = (NW > DW + EW) ? NW : DW + EW;
  localparam logic [EW:0] MAXP  = {2'b00, {(EW-1){1'b1}}};
  localparam logic [EW:0] MINP1 = {2'b01, {(EW-1){1'b0}}};

  typedef struct packed {
    logic                     vld;
    logic                     zero;
    logic [NE-1:0]            neg;
    logic [NE-1:0]            sat;
    logic [DW-1:0]            dmag;
    logic [NE-1:0][XW-1:0]    rem;
    logic [NE-1:0][EW-1:0]    q;
  } dv_t;

  typedef struct packed {
    logic                     vld;
    logic                     zero;
    logic [NE-1:0]            neg;
    logic [NE-1:0]            sat;
    logic [NE-1:0][EW:0]      qr;
  } rn_t;

  dv_t st_r   [EW+1];
  dv_t st_nxt [EW+1];
  rn_t rn_r, rn_nxt;

  // Entry: scale numerators, flag quotients that cannot fit
  always_comb begin
    st_nxt[0].vld  = di.vld;
    st_nxt[0].zero = di.zero;
    st_nxt[0].neg  = di.neg;
    st_nxt[0].dmag = di.dmag;
    st_nxt[0].q    = '0;
    for (int k = 0; k < NE; k++) begin
      st_nxt[0].rem[k] = XW'(di.cmag[k]) << (2 * FRAC_BITS);
      st_nxt[0].sat[k] = (XW'(di.cmag[k]) << (2 * FRAC_BITS)) >= (XW'(di.dmag) << EW);
    end
  end

  // One restoring step per stage, MSB first
  for (genvar j = 0; j < EW; j++) begin : g_step
    localparam int B = EW - 1 - j;
    always_comb begin
      st_nxt[j+1] = st_r[j];
      for (int k = 0; k < NE; k++) begin
        if (st_r[j].rem[k] >= (XW'(st_r[j].dmag) << B)) begin
          st_nxt[j+1].rem[k]  = st_r[j].rem[k] - (XW'(st_r[j].dmag) << B);
          st_nxt[j+1].q[k][B] = 1'b1;
        end
      end
    end
  end

  for (genvar j = 0; j <= EW; j++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) st_r[j].vld <= 1'b0;
      else if (en) st_r[j] <= st_nxt[j];
    end
  end

  // Round to nearest, ties away from zero
  always_comb begin
    rn_nxt.vld  = st_r[EW].vld;
    rn_nxt.zero = st_r[EW].zero;
    rn_nxt.neg  = st_r[EW].neg;
    rn_nxt.sat  = st_r[EW].sat;
    for (int k = 0; k < NE; k++) begin
      rn_nxt.qr[k] = {1'b0, st_r[EW].q[k]}
                   + {{EW{1'b0}},
                      ((st_r[EW].rem[k] << 1) >= XW'(st_r[EW].dmag))};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rn_r.vld <= 1'b0;
    else if (en) rn_r <= rn_nxt;
  end

  // Saturate and apply sign
  always_comb begin
    ro.vld      = rn_r.vld;
    ro.singular = rn_r.zero;
    for (int k = 0; k < NE; k++) begin
      priority if (rn_r.zero) begin
        ro.q[k] = '0;
      end else if (rn_r.neg[k]) begin
        ro.q[k] = (rn_r.sat[k] || rn_r.qr[k] > MINP1) ? MINP1[EW-1:0]
                                                      : (~rn_r.qr[k][EW-1:0] + 1'b1);
      end else begin
        ro.q[k] = (rn_r.sat[k] || rn_r.qr[k] > MAXP) ? MAXP[EW-1:0]
                                                     : rn_r.qr[k][EW-1:0];
      end
    end
  end

endmodule

// ===== design/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by adjugate and pipelined restoring division.
// Pipeline registers from accepted word to out_valid (Q8.8 at the default FRAC_BITS):
//   2 cofactor, 3 determinant, 16+1 divide, 1 round, 1 output register.
// Throughput: one matrix per cycle while in_stall is low; the divider has one quotient bit per stage.
// in_stall rises only when the output is held and the skid register is full.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  m3i_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output m3i_pkg::out_word_t  out_word
);
  import m3i_pkg::*;

  logic      en;
  logic      take;
  mat_in_t   mi;
  cof_b_t    cb;
  div_in_t   dvi;
  res_t      res;
  out_word_t res_word;
  out_word_t out_r, skid_r;
  logic      out_valid_r, skid_vld_r;

  // Pipeline moves unless the skid register is occupied
  assign en       = ~skid_vld_r;
  assign in_stall = skid_vld_r;
  assign take     = out_valid_r & ~out_stall;

  assign mi.vld  = in_valid;
  assign mi.m[0] = in_word.in_0;
  assign mi.m[1] = in_word.in_1;
  assign mi.m[2] = in_word.in_2;
  assign mi.m[3] = in_word.in_3;
  assign mi.m[4] = in_word.in_4;
  assign mi.m[5] = in_word.in_5;
  assign mi.m[6] = in_word.in_6;
  assign mi.m[7] = in_word.in_7;
  assign mi.m[8] = in_word.in_8;

  m3i_cof u_cof (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .mi    (mi),
    .co    (cb)
  );

  m3i_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ci    (cb),
    .dv    (dvi)
  );

  m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .di    (dvi),
    .ro    (res)
  );

  assign res_word.out_0    = res.q[0];
  assign res_word.out_1    = res.q[1];
  assign res_word.out_2    = res.q[2];
  assign res_word.out_3    = res.q[3];
  assign res_word.out_4    = res.q[4];
  assign res_word.out_5    = res.q[5];
  assign res_word.out_6    = res.q[6];
  assign res_word.out_7    = res.q[7];
  assign res_word.out_8    = res.q[8];
  assign res_word.singular = res.singular;

  // Output register with one-word skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_vld_r) begin
        out_r       <= skid_r;
        out_valid_r <= 1'b1;
        skid_vld_r  <= 1'b0;
      end else begin
        out_r       <= res_word;
        out_valid_r <= res.vld;
      end
    end else if (en && res.vld) begin
      skid_r     <= res_word;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Skid only fills behind a held output word
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled while output was free");

  a_skid_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid holds a word with output empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid_r && out_stall))
    else $error("input stalled without output backpressure");

  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.singular) |->
      (out_r.out_0 == '0 && out_r.out_1 == '0 && out_r.out_2 == '0 &&
       out_r.out_3 == '0 && out_r.out_4 == '0 && out_r.out_5 == '0 &&
       out_r.out_6 == '0 && out_r.out_7 == '0 && out_r.out_8 == '0))
    else $error("singular word with nonzero elements");

endmodule
